### rtl/core/hrlp_pkg.sv
package hrlp_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_METHOD  = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_VERSION = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // Token positions within the request line.
  localparam logic [1:0] TOK_METHOD  = 2'd0;
  localparam logic [1:0] TOK_PATH    = 2'd1;
  localparam logic [1:0] TOK_VERSION = 2'd2;
  localparam logic [1:0] TOK_DROP    = 2'd3;

  // Escape decoding phases.
  localparam logic [1:0] PH_NONE    = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_HELD    = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;

  // Results a single byte can cause at most, and the result queue depth.
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic [1:0] tok;
    logic       in_tok;
    logic       started;
    logic       done;
    logic [7:0] cnt;
    logic [1:0] phase;
    logic [7:0] held;
    logic       cut;
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       ok;
    logic       lor;
  } res_t;

endpackage

### rtl/core/http_request_line_parser_unit.sv
// HTTP request-line parser with percent decoding of the path.
// Raw request bytes enter on the slave stream, one byte per transfer; tlast
// marks the final byte of a request buffer. Results leave on the master
// stream: tuser carries the kind (method, path, version or end), tdata the
// byte and, for the end item, the flag saying all three tokens were found;
// tlast marks the final result caused by one input byte.
// Each accepted byte is held in an input register and, once the result queue
// can take all its results, is processed by a single pass of combinational
// logic into the result queue, from which the results are read.
// Throughput is one byte per cycle; a byte causes up to three results, and
// the output drains one result per cycle, so the input pauses only while the
// eight-entry result queue has fewer than three free places.
// Reset clears the parser state, the input register and the queue; the
// next byte then starts a new request. When the receiver stalls, results
// wait in the queue and input is taken until the queue is nearly full.
module http_request_line_parser_unit #(
  parameter int METHOD_LEN  = 15,
  parameter int PATH_LEN    = 255,
  parameter int VERSION_LEN = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] value, [8] ok, [15:9] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_of_run
);

  // Input register: one byte waiting for the processing pass.
  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_last;
  logic           room;
  logic           fire;
  logic [1:0]     wr_count;
  hrlp_pkg::res_t wr_data [hrlp_pkg::MAX_RES];
  hrlp_pkg::res_t rd_data;

  // A byte is processed once the queue can take every result it may cause.
  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  hrlp_step #(
    .METHOD_LEN  (METHOD_LEN),
    .PATH_LEN    (PATH_LEN),
    .VERSION_LEN (VERSION_LEN)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .wr_count (wr_count),
    .wr_data  (wr_data)
  );

  hrlp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_data  (wr_data),
    .room     (room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (rd_data)
  );

  assign m_tdata = {7'b0, rd_data.ok, rd_data.value};
  assign m_tuser = rd_data.kind;
  assign m_tlast = rd_data.lor;

endmodule

### rtl/core/hrlp_step.sv
module hrlp_step #(
  parameter int METHOD_LEN  = 15,
  parameter int PATH_LEN    = 255,
  parameter int VERSION_LEN = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic [1:0]          wr_count,
  output hrlp_pkg::res_t      wr_data [hrlp_pkg::MAX_RES]
);

  localparam logic [7:0] LIM_METHOD  = 8'(METHOD_LEN);
  localparam logic [7:0] LIM_PATH    = 8'(PATH_LEN);
  localparam logic [7:0] LIM_VERSION = 8'(VERSION_LEN);

  typedef struct packed {
    hrlp_pkg::state_t st;
    logic             fire;
  } emit_t;

  hrlp_pkg::state_t state;
  hrlp_pkg::state_t state_next;
  hrlp_pkg::res_t   res [hrlp_pkg::MAX_RES];
  logic [1:0]       n;
  emit_t            e;
  logic [1:0]       ph;
  logic [4:0]       hi;
  logic [4:0]       lo;
  logic [7:0]       v;
  logic             do_end;

  // Hex digit: bit 4 marks a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic emit_t field_emit(input hrlp_pkg::state_t s, input logic [7:0] val);
    emit_t      r;
    logic [7:0] lim;
    r.st   = s;
    r.fire = 1'b0;
    lim    = (s.tok == hrlp_pkg::TOK_METHOD) ? LIM_METHOD :
             (s.tok == hrlp_pkg::TOK_PATH)   ? LIM_PATH : LIM_VERSION;
    if (s.tok != hrlp_pkg::TOK_DROP) begin
      if (s.tok == hrlp_pkg::TOK_PATH && s.cut) begin
        r.fire = 1'b0;
      end else if (s.tok == hrlp_pkg::TOK_PATH && val == hrlp_pkg::CH_NUL) begin
        r.st.cut = 1'b1;
      end else if (s.cnt < lim) begin
        r.fire   = 1'b1;
        r.st.cnt = s.cnt + 8'd1;
      end
    end
    return r;
  endfunction

  always_comb begin
    state_next = state;
    n          = '0;
    e          = '0;
    ph         = hrlp_pkg::PH_NONE;
    hi         = hex_dec(state.held);
    lo         = hex_dec(in_byte);
    v          = '0;
    do_end     = in_last;
    for (int i = 0; i < hrlp_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end

    // Byte handling within the line.
    if (!state_next.done) begin
      if (in_byte == hrlp_pkg::CH_NUL) begin
        do_end = 1'b1;
      end else if (in_byte == hrlp_pkg::CH_LF) begin
        if (state_next.started) begin
          do_end = 1'b1;
        end
      end else begin
        state_next.started = 1'b1;
        if (in_byte == hrlp_pkg::CH_SPACE) begin
          if (state_next.in_tok) begin
            do_end = 1'b1;
          end
        end else begin
          if (!state_next.in_tok) begin
            state_next.in_tok = 1'b1;
            state_next.cnt    = '0;
            state_next.phase  = hrlp_pkg::PH_NONE;
          end
          e.fire = 1'b0;
          if (state_next.tok == hrlp_pkg::TOK_PATH) begin
            if (state_next.phase == hrlp_pkg::PH_NONE) begin
              if (in_byte == hrlp_pkg::CH_PERCENT) begin
                state_next.phase = hrlp_pkg::PH_PERCENT;
              end else begin
                v = (in_byte == hrlp_pkg::CH_PLUS) ? hrlp_pkg::CH_SPACE : in_byte;
                e = field_emit(state_next, v);
              end
            end else if (state_next.phase == hrlp_pkg::PH_PERCENT) begin
              state_next.held  = in_byte;
              state_next.phase = hrlp_pkg::PH_HELD;
            end else begin
              if (hi[4]) v = lo[4] ? {hi[3:0], lo[3:0]} : {4'h0, hi[3:0]};
              state_next.phase = hrlp_pkg::PH_NONE;
              e = field_emit(state_next, v);
            end
          end else begin
            v = in_byte;
            e = field_emit(state_next, v);
          end
          if (e.fire) begin
            res[n] = '{kind: state_next.tok, value: v, ok: 1'b0, lor: 1'b0};
            n = n + 2'd1;
          end
          if (e.fire || (e.st.cut != state_next.cut)) begin
            state_next = e.st;
          end
        end
      end
      if (in_byte == hrlp_pkg::CH_NUL || (in_byte == hrlp_pkg::CH_LF && state.started)) begin
        state_next.done = 1'b1;
      end
    end

    // Closing the current token; a cut-off escape is released as a percent sign and any held byte, plus read as space.
    if (do_end) begin
      if (state_next.tok == hrlp_pkg::TOK_PATH && state_next.in_tok &&
          state_next.phase != hrlp_pkg::PH_NONE) begin
        ph               = state_next.phase;
        state_next.phase = hrlp_pkg::PH_NONE;
        e = field_emit(state_next, hrlp_pkg::CH_PERCENT);
        state_next = e.st;
        if (e.fire) begin
          res[n] = '{kind: state_next.tok, value: hrlp_pkg::CH_PERCENT, ok: 1'b0, lor: 1'b0};
          n = n + 2'd1;
        end
        if (ph == hrlp_pkg::PH_HELD) begin
          v = (state_next.held == hrlp_pkg::CH_PLUS) ? hrlp_pkg::CH_SPACE : state_next.held;
          e = field_emit(state_next, v);
          state_next = e.st;
          if (e.fire) begin
            res[n] = '{kind: state_next.tok, value: v, ok: 1'b0, lor: 1'b0};
            n = n + 2'd1;
          end
        end
      end
      state_next.phase = hrlp_pkg::PH_NONE;
      if (state_next.in_tok) begin
        state_next.in_tok = 1'b0;
        if (state_next.tok != hrlp_pkg::TOK_DROP) state_next.tok = state_next.tok + 2'd1;
      end
      state_next.cnt = '0;
    end

    if (in_last) begin
      res[n] = '{kind: hrlp_pkg::KIND_END, value: 8'h00,
                 ok: (state_next.tok == hrlp_pkg::TOK_DROP), lor: 1'b0};
      n = n + 2'd1;
      state_next = '0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].lor = 1'b1;
    end
  end

  assign wr_count = fire ? n : 2'd0;
  assign wr_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  a_last_gives_end: assert property (@(posedge clk) disable iff (rst)
    (fire && in_last) |-> (wr_count != 2'd0 && wr_data[wr_count - 2'd1].kind == hrlp_pkg::KIND_END))
    else $error("last byte produced no end item");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    !fire |-> (wr_count == 2'd0))
    else $error("results written without a byte being processed");
  a_lor_on_final: assert property (@(posedge clk) disable iff (rst)
    (wr_count != 2'd0) |-> wr_data[wr_count - 2'd1].lor)
    else $error("final result of a byte lacks its run marker");

endmodule

### rtl/core/hrlp_fifo.sv
module hrlp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     wr_count,
  input  hrlp_pkg::res_t wr_data [hrlp_pkg::MAX_RES],
  output logic           room,
  output logic           rd_valid,
  input  logic           rd_ready,
  output hrlp_pkg::res_t rd_data
);

  localparam int AW = $clog2(hrlp_pkg::FIFO_DEPTH);

  hrlp_pkg::res_t mem [hrlp_pkg::FIFO_DEPTH];
  logic [AW-1:0]  head;
  logic [AW-1:0]  tail;
  logic [AW:0]    count;
  logic           pop;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[head];
  assign pop      = rd_valid && rd_ready;
  assign room     = (count <= (AW+1)'(hrlp_pkg::FIFO_DEPTH - hrlp_pkg::MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < hrlp_pkg::MAX_RES; i++) begin
      if (2'(i) < wr_count) begin
        mem[tail + AW'(i)] <= wr_data[i];
      end
    end
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + AW'(wr_count);
      head  <= head + AW'(pop);
      count <= count + (AW+1)'(wr_count) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(hrlp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");
  a_write_fits: assert property (@(posedge clk) disable iff (rst)
    (wr_count != 2'd0) |-> ((AW+2)'(count) + (AW+2)'(wr_count) <= (AW+2)'(hrlp_pkg::FIFO_DEPTH)))
    else $error("write exceeds queue space");
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) + (AW+1)'($past(wr_count)) - (AW+1)'($past(pop))))
    else $error("queue occupancy out of step");

endmodule
